### src/ttce_pkg.sv
// ----------------------------------------------------------------------------
// ttce_pkg: shared types and constants for the text terminal cursor engine
// grid geometry, character codes, result kinds and the result record
// ----------------------------------------------------------------------------
`default_nettype none

package ttce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IS_ACTIVE  = 4'd1;
  localparam logic [ATTR_W-1:0]    TEXT_COLOR_RST = 8'd7;

  // character codes
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_PRINT_HI  = 8'h7E;

  // result item payload widths
  localparam int OUT_DATA_W = 32;  // row, column, glyph, color, zero fill
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_MOVE   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] glyph;
    logic [ATTR_W-1:0] color;
    logic              last;
  } result_t;

  localparam result_t RESULT_NONE = '{kind: KIND_WRITE, row: '0, column: '0,
                                      glyph: '0, color: '0, last: 1'b0};

endpackage

`default_nettype wire

### src/text_terminal_cursor_engine.sv
// the first result item of a character is offered in the cycle after it is taken
// throughput: one character per cycle while each yields at most one result item and
//   the output is not stalled; a character with n > 1 result items (n is at most 3)
//   holds the input while the single result channel drains the three-entry buffer
// reset (rst_n low, synchronous): cursor at row 0 column 0, text color 7,
//   terminal active, result buffer empty
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine: cursor tracking for a text-mode terminal
// turns character bytes into cell writes, scroll-up and cursor-move commands
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cursor_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // character input
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ttce_pkg::CHAR_W-1:0]       in_tdata,   // [7:0] char_code
  // command output
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ttce_pkg::OUT_DATA_W-1:0]        out_tdata,  // [4:0] row, [11:5] column,
                                                             // [19:12] glyph, [27:20] color,
                                                             // [31:28] zero
  output logic [ttce_pkg::OUT_USER_W-1:0]        out_tuser,  // [1:0] kind
  output logic                                   out_tlast,  // last command of a character
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ttce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ttce_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import ttce_pkg::*;

  // grid edges at the cursor widths
  localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(ROWS);
  localparam logic [COL_W-1:0] COL_END = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_END = ROW_W'(ROWS - 1);

  // configuration registers
  logic [ATTR_W-1:0] text_color_r;
  logic              is_active_r;

  // cursor state
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;

  // result buffer: slot 0 drives the output ports
  result_t    slot_r   [3];
  result_t    slot_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;

  // results of the character at the input
  result_t    res   [3];
  logic [1:0] res_n;

  logic in_acc, out_acc;
  logic printable, do_write, do_scroll, do_move;
  logic [CHAR_W-1:0] glyph;
  logic [ROW_W-1:0]  wr_row;
  logic [COL_W-1:0]  wr_col;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;

  assign cfg_ready = 1'b1;

  // a new character may enter when the buffer is empty or empties in this cycle
  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {4'b0, slot_r[0].color, slot_r[0].glyph,
                       slot_r[0].column, slot_r[0].row};
  assign out_tuser  = slot_r[0].kind;
  assign out_tlast  = slot_r[0].last;

  assign printable = (in_tdata >= CODE_PRINT_LO) && (in_tdata <= CODE_PRINT_HI);
  assign col_inc   = {1'b0, cur_col_r} + 1'b1;
  assign row_inc   = {1'b0, cur_row_r} + 1'b1;

  // cursor update and the flags of the commands this character causes
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    do_write    = 1'b0;
    do_scroll   = 1'b0;
    do_move     = 1'b0;
    glyph       = in_tdata;
    wr_row      = cur_row_r;
    wr_col      = cur_col_r;
    if (printable) begin
      do_write = 1'b1;
      do_move  = is_active_r;
      if (col_inc >= COL_LIMIT) begin
        // wrap to the next row, scroll at the bottom
        cur_col_nxt = '0;
        if (row_inc >= ROW_LIMIT) begin
          cur_row_nxt = ROW_END;
          do_scroll   = 1'b1;
        end else begin
          cur_row_nxt = row_inc[ROW_W-1:0];
        end
      end else begin
        cur_col_nxt = col_inc[COL_W-1:0];
      end
    end else if (in_tdata == CODE_NEWLINE) begin
      do_move     = is_active_r;
      cur_col_nxt = '0;
      if (row_inc >= ROW_LIMIT) begin
        cur_row_nxt = ROW_END;
        do_scroll   = 1'b1;
      end else begin
        cur_row_nxt = row_inc[ROW_W-1:0];
      end
    end else if (in_tdata == CODE_RETURN) begin
      cur_col_nxt = '0;
    end else if (in_tdata == CODE_BACKSPACE) begin
      do_write = 1'b1;
      do_move  = is_active_r;
      glyph    = CODE_SPACE;
      if (cur_col_r == '0) begin
        // step back to the end of the previous row, origin stays put
        if (cur_row_r != '0) begin
          cur_col_nxt = COL_END;
          cur_row_nxt = cur_row_r - 1'b1;
        end
      end else begin
        cur_col_nxt = cur_col_r - 1'b1;
      end
      wr_row = cur_row_nxt;
      wr_col = cur_col_nxt;
    end
  end

  // pack the commands in order: write, scroll, move
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = RESULT_NONE;
    end
    res_n = 2'd0;
    if (do_write) begin
      res[res_n] = '{kind: KIND_WRITE, row: wr_row, column: wr_col,
                     glyph: glyph, color: text_color_r, last: 1'b0};
      res_n = res_n + 1'b1;
    end
    if (do_scroll) begin
      res[res_n] = '{kind: KIND_SCROLL, row: '0, column: '0,
                     glyph: '0, color: '0, last: 1'b0};
      res_n = res_n + 1'b1;
    end
    if (do_move) begin
      res[res_n] = '{kind: KIND_MOVE, row: cur_row_nxt, column: cur_col_nxt,
                     glyph: '0, color: '0, last: 1'b0};
      res_n = res_n + 1'b1;
    end
    if (res_n != 2'd0) begin
      res[res_n - 1'b1].last = 1'b1;
    end
  end

  // buffer: load on a new character, shift down as items leave
  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (in_acc) begin
      slot_nxt = res;
      cnt_nxt  = res_n;
    end else if (out_acc) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (!rst_n) begin
      cnt_r        <= 2'd0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      text_color_r <= TEXT_COLOR_RST;
      is_active_r  <= 1'b1;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEXT_COLOR: text_color_r <= cfg_data;
          REG_IS_ACTIVE:  is_active_r  <= cfg_data[0];
          default:        ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  // cursor never leaves the grid
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_row_r} < ROW_LIMIT) && ({1'b0, cur_col_r} < COL_LIMIT))
    else $error("cursor outside the grid");

  // the item on the output is marked last exactly when it is the only one left
  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (cnt_r == 2'd1)))
    else $error("tlast does not match buffer fill");

  // a new character never overwrites results still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tvalid) |-> (out_tready && cnt_r == 2'd1))
    else $error("input taken while results pending");

  // a waiting item holds until it is taken
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output item changed");
`endif

endmodule

`default_nettype wire

### tb/text_terminal_cursor_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_tb: self-checking bench for the cursor engine
// streams character bytes in and checks every cell write, scroll and cursor
// move against a cycle-free cursor predictor, under random stalls and gaps
// on both streams and across several color and active-terminal settings
// ----------------------------------------------------------------------------

module text_terminal_cursor_engine_tb;
  import ttce_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata  = '0;     // [7:0] char_code
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // [4:0] row, [11:5] column,
                                             // [19:12] glyph, [27:20] color
  logic [OUT_USER_W-1:0] out_tuser;          // [1:0] kind
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data  = '0;

  text_terminal_cursor_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // cursor predictor state, starts at the reset values of the block
  logic [ROW_W-1:0]  cur_row     = '0;
  logic [COL_W-1:0]  cur_col     = '0;
  logic [ATTR_W-1:0] text_attr   = TEXT_COLOR_RST;
  logic              term_active = 1'b1;

  result_t char_cmds[$];      // commands of the character being predicted
  result_t expected_cmds[$];  // commands still owed by the block, oldest first

  int  errors        = 0;
  int  cycles        = 0;
  int  chars_sent    = 0;
  int  cmds_checked  = 0;
  int  scrolls_seen  = 0;
  int  moves_seen    = 0;
  int  settings_done = 0;
  int  stall_left    = 0;
  bit  idle_on       = 1'b1;  // random gaps and stalls, off for the last part

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still owed", cycles,
               expected_cmds.size());
      $display("FAIL text_terminal_cursor_engine");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // cursor predictor
  // ---------------------------------------------------------------------------

  function automatic void note_cmd(kind_t k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                   logic [CHAR_W-1:0] g, logic [ATTR_W-1:0] a);
    result_t cmd;
    cmd = '{kind: k, row: r, column: c, glyph: g, color: a, last: 1'b0};
    char_cmds.push_back(cmd);
  endfunction

  // next row, or a scroll when already on the bottom row
  function automatic void step_down();
    if (cur_row == ROWS - 1)
      note_cmd(KIND_SCROLL, '0, '0, '0, '0);
    else
      cur_row++;
  endfunction

  function automatic void note_move();
    if (term_active)
      note_cmd(KIND_MOVE, cur_row, cur_col, '0, '0);
  endfunction

  function automatic void predict_char(logic [CHAR_W-1:0] code);
    char_cmds.delete();
    if (code >= CODE_PRINT_LO && code <= CODE_PRINT_HI) begin
      note_cmd(KIND_WRITE, cur_row, cur_col, code, text_attr);
      if (cur_col == COLUMNS - 1) begin
        cur_col = '0;
        step_down();
      end else begin
        cur_col++;
      end
      note_move();
    end else if (code == CODE_NEWLINE) begin
      step_down();
      cur_col = '0;
      note_move();
    end else if (code == CODE_RETURN) begin
      // column only, nothing is emitted
      cur_col = '0;
    end else if (code == CODE_BACKSPACE) begin
      // at the origin the cursor stays put but the space is still written
      if (cur_col == 0) begin
        if (cur_row != 0) begin
          cur_col = COL_W'(COLUMNS - 1);
          cur_row--;
        end
      end else begin
        cur_col--;
      end
      note_cmd(KIND_WRITE, cur_row, cur_col, CODE_SPACE, text_attr);
      note_move();
    end
    // every other byte is ignored
    foreach (char_cmds[i]) begin
      if (i == char_cmds.size() - 1)
        char_cmds[i].last = 1'b1;
      expected_cmds.push_back(char_cmds[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want)
      report_mismatch($sformatf("command %0d %s: expected %0d, got %0d",
                                cmds_checked, name, want, got));
  endtask

  always @(posedge clk) begin : check_cmds
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = kind_t'(out_tuser);
      got.row    = out_tdata[4:0];
      got.column = out_tdata[11:5];
      got.glyph  = out_tdata[19:12];
      got.color  = out_tdata[27:20];
      got.last   = out_tlast;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command kind %0d row %0d column %0d",
                                  got.kind, got.row, got.column));
      end else begin
        want = expected_cmds.pop_front();
        compare_field("kind",   8'(want.kind),   8'(got.kind));
        compare_field("row",    8'(want.row),    8'(got.row));
        compare_field("column", 8'(want.column), 8'(got.column));
        compare_field("glyph",  want.glyph,      got.glyph);
        compare_field("color",  want.color,      got.color);
        compare_field("last",   8'(want.last),   8'(got.last));
        if (want.kind == KIND_SCROLL) scrolls_seen++;
        if (want.kind == KIND_MOVE) moves_seen++;
        cmds_checked++;
      end
    end
  end

  // random result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // valid stays high between back-to-back items, it only drops for a gap
  task automatic send_char(input logic [CHAR_W-1:0] code);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tdata  <= code;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_char(code);
    chars_sent++;
  endtask

  // all owed commands out, then a settling wait for items that emit nothing
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, then a write to an unused index that must change nothing
  task automatic write_regs(input logic [ATTR_W-1:0] attr, input logic active);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TEXT_COLOR;
    cfg_data  <= attr;
    do @(posedge clk); while (!cfg_ready);
    text_attr = attr;
    cfg_index <= REG_IS_ACTIVE;
    cfg_data  <= {(CFG_DAT_W-1)'($urandom), active};  // upper bits are don't-care
    do @(posedge clk); while (!cfg_ready);
    term_active = active;
    cfg_index <= CFG_IDX_W'($urandom_range(REG_IS_ACTIVE + 1, 2**CFG_IDX_W - 1));
    cfg_data  <= CFG_DAT_W'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // mostly printable, some control bytes, some fully random bytes
  function automatic logic [CHAR_W-1:0] pick_char();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 11) return CHAR_W'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI));
    if (roll < 13) return CODE_NEWLINE;
    if (roll < 15) return CODE_BACKSPACE;
    if (roll < 16) return CODE_RETURN;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, ignored bytes, backspace at the origin and across a row
  task automatic test_directed();
    logic [CHAR_W-1:0] codes[$];
    codes = '{CODE_BACKSPACE, CODE_RETURN, CODE_SPACE, CODE_PRINT_HI, 8'h1F, 8'h7F,
              8'h80, 8'hFF, 8'h00, 8'h21, CODE_NEWLINE, CODE_BACKSPACE, 8'h41,
              CODE_RETURN, CODE_NEWLINE, 8'h7A, CODE_BACKSPACE, 8'h09, 8'h1B,
              CODE_BACKSPACE};
    foreach (codes[i]) send_char(codes[i]);
    wait_idle();
  endtask

  // color and active extremes, a short random burst under each
  task automatic test_register_settings();
    logic [ATTR_W-1:0] attrs[4];
    logic              acts[4];
    attrs = '{8'h00, 8'hFF, 8'hFF, ATTR_W'($urandom)};
    acts  = '{1'b0, 1'b1, 1'b0, 1'b1};
    foreach (attrs[i]) begin
      write_regs(attrs[i], acts[i]);
      repeat (15) send_char(pick_char());
      wait_idle();
    end
  endtask

  // text shaped as lines: mostly short, some long enough to wrap, ended by
  // newlines (sometimes several, to reach the bottom row), returns or backspaces
  task automatic test_text_lines(input int target);
    int first;
    int line_len;
    first = chars_sent;
    while (chars_sent - first < target) begin
      line_len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 6);
      // keep the last line inside the budget
      if (line_len > target - (chars_sent - first))
        line_len = target - (chars_sent - first);
      repeat (line_len) begin
        if ($urandom_range(0, 15) == 0)
          send_char(pick_char());
        else
          send_char(CHAR_W'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI)));
      end
      case ($urandom_range(0, 7))
        0:       send_char(CODE_RETURN);
        1:       repeat ($urandom_range(1, 3)) send_char(CODE_BACKSPACE);
        6, 7:    repeat ($urandom_range(2, 8)) send_char(CODE_NEWLINE);
        default: send_char(CODE_NEWLINE);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_settings();
    repeat (3) begin
      write_regs(ATTR_W'($urandom), $urandom_range(0, 3) != 0);
      test_text_lines(100);
      wait_idle();
    end

    // final stretch at full rate on both sides
    idle_on = 1'b0;
    write_regs(TEXT_COLOR_RST, 1'b1);
    test_text_lines(60);
    wait_idle();

    $display("sent %0d characters over %0d register settings, checked %0d commands",
             chars_sent, settings_done, cmds_checked);
    $display("  including %0d scrolls and %0d cursor moves, %0d mismatches",
             scrolls_seen, moves_seen, errors);
    if (errors == 0)
      $display("PASS text_terminal_cursor_engine");
    else
      $display("FAIL text_terminal_cursor_engine");
    $finish;
  end

endmodule

### filelist.f
src/ttce_pkg.sv
src/text_terminal_cursor_engine.sv
tb/text_terminal_cursor_engine_tb.sv
